### rtl/core/lpc_pkg.sv
// Shared constants, codes and types of the local peak clip filter.
`default_nettype none

package lpc_pkg;

    localparam int PIXEL_W   = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int RESET_DIM      = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                command;
        logic [PIXEL_W-1:0]  pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel_out;
        logic                frame_last;
    } out_item_t;

    typedef struct packed {
        logic act;
        logic write;
        logic emit;
        logic up;
        logic down;
        logic left;
        logic right;
        logic last;
    } item_flags_t;

endpackage

`default_nettype wire

### rtl/core/lpc_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
`default_nettype none

interface lpc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/lpc_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module lpc_ram #(
    parameter int WIDTH = 2 * lpc_pkg::PIXEL_W,
    parameter int DEPTH = lpc_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

### rtl/core/lpc_seq.sv
// Configuration registers and raster position counters of the filter.
`default_nettype none

module lpc_seq #(
    parameter int MAX_WIDTH  = lpc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lpc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [lpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lpc_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            accept,
    input  wire logic                            command,
    output lpc_pkg::item_flags_t                 flags,
    output logic [$clog2(MAX_WIDTH)-1:0]         col,
    output logic [$clog2(MAX_WIDTH)-1:0]         col_next
);
    import lpc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_RST = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
    localparam int H_RST = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

    logic [COL_W-1:0] w_last_reg, w_last_next;
    logic [ROW_W-1:0] h_last_reg, h_last_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic             in_done_reg, in_done_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic is_pix;
    logic write_item;
    logic emit_item;
    logic last_item;

    always_comb
    begin
        is_pix     = (command == CMD_PIXEL);
        write_item = is_pix && !in_done_reg;
        emit_item  = (write_item && (in_row_reg != '0)) || (!is_pix && in_done_reg);
        last_item  = emit_item && (out_col_reg == w_last_reg) && (out_row_reg == h_last_reg);

        flags.act   = write_item || emit_item;
        flags.write = write_item;
        flags.emit  = emit_item;
        flags.up    = (out_row_reg != '0);
        flags.down  = is_pix;
        flags.left  = (out_col_reg != '0);
        flags.right = (out_col_reg != w_last_reg);
        flags.last  = last_item;

        col      = is_pix ? in_col_reg : out_col_reg;
        col_next = (col == w_last_reg) ? col : col + COL_W'(1);
    end

    always_comb
    begin
        w_last_next  = w_last_reg;
        h_last_next  = h_last_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    if (cfg_data == '0)
                    begin
                        w_last_next = '0;
                    end
                    else if (32'(cfg_data) > MAX_WIDTH)
                    begin
                        w_last_next = COL_W'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        w_last_next = COL_W'(cfg_data - CFG_W'(1));
                    end
                end
                CFG_FRAME_HEIGHT:
                begin
                    if (cfg_data == '0)
                    begin
                        h_last_next = '0;
                    end
                    else if (32'(cfg_data) > MAX_HEIGHT)
                    begin
                        h_last_next = ROW_W'(MAX_HEIGHT - 1);
                    end
                    else
                    begin
                        h_last_next = ROW_W'(cfg_data - CFG_W'(1));
                    end
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (write_item)
            begin
                if (in_col_reg == w_last_reg)
                begin
                    in_col_next = '0;
                    if (in_row_reg == h_last_reg)
                    begin
                        in_row_next  = '0;
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            if (emit_item)
            begin
                if (last_item)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    in_done_next = 1'b0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_reg == w_last_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg  <= COL_W'(W_RST - 1);
            h_last_reg  <= ROW_W'(H_RST - 1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            w_last_reg  <= w_last_next;
            h_last_reg  <= h_last_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // While rows are still arriving, the output position trails the input by one row.
    a_out_trails_in: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_done_reg && (in_row_reg != '0)) |->
            ((out_col_reg == in_col_reg) && ((out_row_reg + ROW_W'(1)) == in_row_reg)))
        else $error("output position does not trail input by one row");

    a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_done_reg && (in_row_reg == '0)) |->
            ((out_col_reg == '0) && (out_row_reg == '0)))
        else $error("output advanced during the first row");

    a_done_parks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_done_reg |-> ((in_col_reg == '0) && (in_row_reg == '0)))
        else $error("input position not parked after the frame was received");
endmodule

`default_nettype wire

### rtl/core/lpc_window.sv
// Two-row line memory with read-modify-write, neighbour window and output register.
`default_nettype none

module lpc_window #(
    parameter int MAX_WIDTH  = lpc_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = lpc_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire lpc_pkg::item_flags_t            flags,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]    col,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]    col_next,
    input  wire logic [lpc_pkg::PIXEL_W-1:0]     pixel,
    output logic                                 ready,
    lpc_stream_if.source                         results
);
    import lpc_pkg::*;

    localparam int SW    = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ENT_W = 2 * SW;

    logic              s1_valid_reg, s1_valid_next;
    item_flags_t       s1_flags_reg, s1_flags_next;
    logic [COL_W-1:0]  s1_col_reg, s1_col_next;
    logic [SW-1:0]     s1_pixel_reg, s1_pixel_next;
    logic              fa_hit_reg, fa_hit_next;
    logic              fb_hit_reg, fb_hit_next;
    logic [ENT_W-1:0]  fwd_data_reg, fwd_data_next;
    logic [SW-1:0]     prev_centre_reg, prev_centre_next;
    logic              out_valid_reg, out_valid_next;
    logic [SW-1:0]     out_pixel_reg, out_pixel_next;
    logic              out_last_reg, out_last_next;

    logic [ENT_W-1:0]  rd_a;
    logic [ENT_W-1:0]  rd_b;
    logic [ENT_W-1:0]  entry_a;
    logic [ENT_W-1:0]  entry_b;
    logic [SW-1:0]     centre;
    logic [SW-1:0]     up_v;
    logic [SW-1:0]     down_v;
    logic [SW-1:0]     left_v;
    logic [SW-1:0]     right_v;
    logic [SW-1:0]     best_ud;
    logic [SW-1:0]     best_lr;
    logic [SW-1:0]     best;
    logic              any_nb;
    logic [SW-1:0]     result;
    logic              s1_adv;
    logic              ram_we;
    logic [ENT_W-1:0]  ram_wdata;

    lpc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col),
        .rdata (rd_a)
    );

    lpc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_next),
        .rdata (rd_b)
    );

    // Each column entry holds the row above in its upper half and the centre row below it.
    always_comb
    begin
        entry_a = fa_hit_reg ? fwd_data_reg : rd_a;
        entry_b = fb_hit_reg ? fwd_data_reg : rd_b;
        centre  = entry_a[SW-1:0];
        up_v    = s1_flags_reg.up    ? entry_a[ENT_W-1:SW] : '0;
        down_v  = s1_flags_reg.down  ? s1_pixel_reg        : '0;
        left_v  = s1_flags_reg.left  ? prev_centre_reg     : '0;
        right_v = s1_flags_reg.right ? entry_b[SW-1:0]     : '0;
        best_ud = (up_v > down_v) ? up_v : down_v;
        best_lr = (left_v > right_v) ? left_v : right_v;
        best    = (best_ud > best_lr) ? best_ud : best_lr;
        any_nb  = s1_flags_reg.up || s1_flags_reg.down || s1_flags_reg.left
                  || s1_flags_reg.right;
        result  = (any_nb && (best < centre)) ? best : centre;

        s1_adv    = s1_valid_reg && (!s1_flags_reg.emit || !out_valid_reg || results.ready);
        ready     = !s1_valid_reg || s1_adv;
        ram_we    = s1_adv && s1_flags_reg.write;
        ram_wdata = {centre, s1_pixel_reg};
    end

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        s1_flags_next    = s1_flags_reg;
        s1_col_next      = s1_col_reg;
        s1_pixel_next    = s1_pixel_reg;
        fa_hit_next      = fa_hit_reg;
        fb_hit_next      = fb_hit_reg;
        fwd_data_next    = fwd_data_reg;
        prev_centre_next = prev_centre_reg;
        out_valid_next   = out_valid_reg;
        out_pixel_next   = out_pixel_reg;
        out_last_next    = out_last_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            if (s1_flags_reg.emit)
            begin
                out_valid_next   = 1'b1;
                out_pixel_next   = result;
                out_last_next    = s1_flags_reg.last;
                prev_centre_next = centre;
            end
        end
        if (accept)
        begin
            s1_valid_next = flags.act;
            s1_flags_next = flags;
            s1_col_next   = col;
            s1_pixel_next = pixel[SW-1:0];
            // The entry written back at this edge is not yet visible to the reads issued with it.
            fa_hit_next   = ram_we && (s1_col_reg == col);
            fb_hit_next   = ram_we && (s1_col_reg == col_next);
            fwd_data_next = ram_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_flags_reg    <= s1_flags_next;
        s1_col_reg      <= s1_col_next;
        s1_pixel_reg    <= s1_pixel_next;
        fa_hit_reg      <= fa_hit_next;
        fb_hit_reg      <= fb_hit_next;
        fwd_data_reg    <= fwd_data_next;
        prev_centre_reg <= prev_centre_next;
        out_pixel_reg   <= out_pixel_next;
        out_last_reg    <= out_last_next;
    end

    assign results.valid           = out_valid_reg;
    assign results.data.pixel_out  = PIXEL_W'(out_pixel_reg);
    assign results.data.frame_last = out_last_reg;

    a_last_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_flags_reg.last) |-> (s1_flags_reg.emit && !s1_flags_reg.write))
        else $error("frame end raised by an item that writes the line memory");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !(s1_adv && s1_flags_reg.emit))
        else $error("pending result overwritten before its transfer");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !ready |-> (s1_valid_reg && s1_flags_reg.emit && out_valid_reg && !results.ready))
        else $error("input stalled without a waiting result");
endmodule

`default_nettype wire

### rtl/core/local_peak_clip_filter.sv
// Local peak clip filter: top level joining the position sequencer and the line-memory window.
// Each result passes through the stage-1 register and then the output register.
// Throughput: one item per cycle unless a result waits on a stalled output; each pixel
// item of the frame does one read-modify-write of one line-memory column, with the write
// of the previous item forwarded to the reads of the next. Reset clears the counters and
// valid flags, sets both frame sizes to 1024 or the maximum if lower; line memory stays as is.
`default_nettype none

module local_peak_clip_filter #(
    parameter int MAX_WIDTH  = lpc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lpc_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = lpc_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [lpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lpc_pkg::CFG_W-1:0]       cfg_data,
    lpc_stream_if.sink                           items,
    lpc_stream_if.source                         results
);
    import lpc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             accept;
    logic             ready;
    item_flags_t      flags;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_next;

    assign items.ready = ready;
    assign accept      = items.valid && ready;

    lpc_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .command   (items.data.command),
        .flags     (flags),
        .col       (col),
        .col_next  (col_next)
    );

    lpc_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .flags    (flags),
        .col      (col),
        .col_next (col_next),
        .pixel    (items.data.pixel_in),
        .ready    (ready),
        .results  (results)
    );
endmodule

`default_nettype wire
